>>> design/lwi_pkg.sv
// ----------------------------------------------------------------------------
// lwi_pkg
// Shared types, constants and the restoring divide step of the interpolator.
// ----------------------------------------------------------------------------
package lwi_pkg;

    localparam int MAX_TARGETS = 16;
    localparam int MAX_STEPS   = 256;
    localparam int TGT_W       = 4;
    localparam int STEP_W      = 8;
    localparam int ADDR_W      = TGT_W + STEP_W;
    localparam int STORE_DEPTH = MAX_TARGETS * MAX_STEPS;

    localparam int DIV_STAGES  = 32;

    localparam logic       REQ_WRITE  = 1'b0;
    localparam logic       REQ_QUERY  = 1'b1;

    localparam logic [1:0] CFG_PERIOD  = 2'd0;
    localparam logic [1:0] CFG_STEPS   = 2'd1;
    localparam logic [1:0] CFG_TARGETS = 2'd2;

    typedef struct packed {
        logic              is_wr;
        logic              err;
        logic [TGT_W-1:0]  tgt;
        logic [STEP_W-1:0] step;
        logic [31:0]       x;
        logic [31:0]       y;
    } t_item;

    typedef struct packed {
        logic is_wr;
        logic err;
    } t_tag;

    // One restoring step: returns {quotient bit, next remainder}.
    function automatic logic [31:0] div_step(input logic [30:0] rem,
                                             input logic        nb,
                                             input logic [30:0] per);
        logic [31:0] trial;
        logic [31:0] diff;
        logic        ge;
        trial = {rem, nb};
        diff  = trial - {1'b0, per};
        ge    = (trial >= {1'b0, per});
        return ge ? {1'b1, diff[30:0]} : {1'b0, trial[30:0]};
    endfunction

endpackage

>>> design/lwi_ram.sv
// ----------------------------------------------------------------------------
// lwi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lwi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> design/lwi_tdiv.sv
// ----------------------------------------------------------------------------
// lwi_tdiv
// Pipelined divide of |time| by the period, one quotient bit per stage; the
// quotient is folded modulo the step count as its bits appear.
// ----------------------------------------------------------------------------
module lwi_tdiv
    import lwi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    input  logic [31:0] i_mag,
    input  logic        i_neg,
    input  logic [30:0] i_period,
    input  logic [8:0]  i_steps,
    output logic        o_valid,
    output t_item       o_item,
    output logic        o_neg,
    output logic [30:0] o_rem,
    output logic [8:0]  o_mod
);

    logic        r_v    [1:DIV_STAGES];
    t_item       r_item [1:DIV_STAGES];
    logic        r_neg  [1:DIV_STAGES];
    logic [30:0] r_rem  [1:DIV_STAGES];
    logic [8:0]  r_mod  [1:DIV_STAGES];
    logic [31:0] r_num  [1:DIV_STAGES-1];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic        v_in;
        t_item       item_in;
        logic        neg_in;
        logic [30:0] rem_in;
        logic [31:0] num_in;
        logic [8:0]  mod_in;
        logic [31:0] step;
        logic [9:0]  m2;
        logic [9:0]  mdiff;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign item_in = i_item;
            assign neg_in  = i_neg;
            assign rem_in  = '0;
            assign num_in  = i_mag;
            assign mod_in  = '0;
        end else begin : g_next
            assign v_in    = r_v[k];
            assign item_in = r_item[k];
            assign neg_in  = r_neg[k];
            assign rem_in  = r_rem[k];
            assign num_in  = r_num[k];
            assign mod_in  = r_mod[k];
        end

        assign step  = div_step(rem_in, num_in[31], i_period);
        // fold the new quotient bit into the running count modulo steps
        assign m2    = {mod_in, step[31]};
        assign mdiff = m2 - {1'b0, i_steps};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_item[k+1] <= item_in;
            r_neg[k+1]  <= neg_in;
            r_rem[k+1]  <= step[30:0];
            r_mod[k+1]  <= (m2 >= {1'b0, i_steps}) ? mdiff[8:0] : m2[8:0];
        end

        if (k < DIV_STAGES - 1) begin : g_shift
            always_ff @(posedge i_clk) begin
                r_num[k+1] <= {num_in[30:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES];
    assign o_item  = r_item[DIV_STAGES];
    assign o_neg   = r_neg[DIV_STAGES];
    assign o_rem   = r_rem[DIV_STAGES];
    assign o_mod   = r_mod[DIV_STAGES];

endmodule

>>> design/lwi_ldiv.sv
// ----------------------------------------------------------------------------
// lwi_ldiv
// Pipelined divide of both axis products by the period, one quotient bit per
// stage, with the base coordinate and sign carried alongside.
// ----------------------------------------------------------------------------
module lwi_ldiv
    import lwi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_tag        i_tag,
    input  logic [30:0] i_period,
    input  logic [62:0] i_num_x,
    input  logic [62:0] i_num_y,
    input  logic        i_neg_x,
    input  logic        i_neg_y,
    input  logic [31:0] i_a_x,
    input  logic [31:0] i_a_y,
    output logic        o_valid,
    output t_tag        o_tag,
    output logic [31:0] o_q_x,
    output logic [31:0] o_q_y,
    output logic        o_neg_x,
    output logic        o_neg_y,
    output logic [31:0] o_a_x,
    output logic [31:0] o_a_y
);

    logic        r_v   [1:DIV_STAGES];
    t_tag        r_tag [1:DIV_STAGES];
    logic        r_nx  [1:DIV_STAGES];
    logic        r_ny  [1:DIV_STAGES];
    logic [31:0] r_ax  [1:DIV_STAGES];
    logic [31:0] r_ay  [1:DIV_STAGES];
    logic [30:0] r_rx  [1:DIV_STAGES];
    logic [30:0] r_ry  [1:DIV_STAGES];
    logic [31:0] r_qx  [1:DIV_STAGES];
    logic [31:0] r_qy  [1:DIV_STAGES];
    logic [31:0] r_lx  [1:DIV_STAGES-1];
    logic [31:0] r_ly  [1:DIV_STAGES-1];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic        v_in;
        t_tag        tag_in;
        logic        nx_in;
        logic        ny_in;
        logic [31:0] ax_in;
        logic [31:0] ay_in;
        logic [30:0] rx_in;
        logic [30:0] ry_in;
        logic [31:0] qx_in;
        logic [31:0] qy_in;
        logic [31:0] lx_in;
        logic [31:0] ly_in;
        logic [31:0] sx;
        logic [31:0] sy;

        if (k == 0) begin : g_first
            // the quotient fits 32 bits, so the top bits start as remainder
            assign v_in   = i_valid;
            assign tag_in = i_tag;
            assign nx_in  = i_neg_x;
            assign ny_in  = i_neg_y;
            assign ax_in  = i_a_x;
            assign ay_in  = i_a_y;
            assign rx_in  = i_num_x[62:32];
            assign ry_in  = i_num_y[62:32];
            assign qx_in  = '0;
            assign qy_in  = '0;
            assign lx_in  = i_num_x[31:0];
            assign ly_in  = i_num_y[31:0];
        end else begin : g_next
            assign v_in   = r_v[k];
            assign tag_in = r_tag[k];
            assign nx_in  = r_nx[k];
            assign ny_in  = r_ny[k];
            assign ax_in  = r_ax[k];
            assign ay_in  = r_ay[k];
            assign rx_in  = r_rx[k];
            assign ry_in  = r_ry[k];
            assign qx_in  = r_qx[k];
            assign qy_in  = r_qy[k];
            assign lx_in  = r_lx[k];
            assign ly_in  = r_ly[k];
        end

        assign sx = div_step(rx_in, lx_in[31], i_period);
        assign sy = div_step(ry_in, ly_in[31], i_period);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k+1] <= tag_in;
            r_nx[k+1]  <= nx_in;
            r_ny[k+1]  <= ny_in;
            r_ax[k+1]  <= ax_in;
            r_ay[k+1]  <= ay_in;
            r_rx[k+1]  <= sx[30:0];
            r_ry[k+1]  <= sy[30:0];
            r_qx[k+1]  <= {qx_in[30:0], sx[31]};
            r_qy[k+1]  <= {qy_in[30:0], sy[31]};
        end

        if (k < DIV_STAGES - 1) begin : g_shift
            always_ff @(posedge i_clk) begin
                r_lx[k+1] <= {lx_in[30:0], 1'b0};
                r_ly[k+1] <= {ly_in[30:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES];
    assign o_tag   = r_tag[DIV_STAGES];
    assign o_q_x   = r_qx[DIV_STAGES];
    assign o_q_y   = r_qy[DIV_STAGES];
    assign o_neg_x = r_nx[DIV_STAGES];
    assign o_neg_y = r_ny[DIV_STAGES];
    assign o_a_x   = r_ax[DIV_STAGES];
    assign o_a_y   = r_ay[DIV_STAGES];

endmodule

>>> design/looped_waypoint_interpolator.sv
// ----------------------------------------------------------------------------
// looped_waypoint_interpolator
// Waypoint table per target with looped, linearly interpolated queries.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// The pipeline holds two 32-stage restoring dividers (step count, fraction).
// Reset: synchronous, active low; clears valid bits and restores the registers.
// The waypoint store is not cleared; an entry must be written before it is read.
module looped_waypoint_interpolator
    import lwi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_wdata,
    input  logic        i_req_type,
    input  logic [3:0]  i_target_sel,
    input  logic [7:0]  i_step_sel,
    input  logic [31:0] i_write_x,
    input  logic [31:0] i_write_y,
    input  logic [31:0] i_query_time,
    output logic        o_valid,
    output logic [31:0] o_pos_x,
    output logic [31:0] o_pos_y,
    output logic        o_range_error
);

    logic [30:0] r_period;
    logic [8:0]  r_steps;
    logic [4:0]  r_targets;

    logic [30:0] per_eff;
    logic [8:0]  steps_eff;
    logic [4:0]  tgt_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= 31'd65536;
            r_steps   <= 9'd256;
            r_targets <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PERIOD:  r_period  <= i_cfg_wdata;
                CFG_STEPS:   r_steps   <= i_cfg_wdata[8:0];
                CFG_TARGETS: r_targets <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    assign per_eff   = (r_period == '0) ? 31'd1 : r_period;
    assign steps_eff = (r_steps == '0) ? 9'd1 :
                       (r_steps > 9'(MAX_STEPS)) ? 9'(MAX_STEPS) : r_steps;
    assign tgt_eff   = (r_targets > 5'(MAX_TARGETS)) ? 5'(MAX_TARGETS) : r_targets;

    assign busy = 1'b0;

    // ---------------- entry stage ----------------
    logic        r_s0_v;
    t_item       r_s0_item;
    logic [31:0] r_s0_mag;
    logic        r_s0_neg;
    t_item       n_s0_item;

    always_comb begin
        n_s0_item.is_wr = (i_req_type == REQ_WRITE);
        n_s0_item.err   = ({1'b0, i_target_sel} >= tgt_eff);
        n_s0_item.tgt   = i_target_sel;
        n_s0_item.step  = i_step_sel;
        n_s0_item.x     = i_write_x;
        n_s0_item.y     = i_write_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else begin
            r_s0_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_item <= n_s0_item;
        r_s0_neg  <= i_query_time[31];
        r_s0_mag  <= i_query_time[31] ? (~i_query_time + 32'd1) : i_query_time;
    end

    // ---------------- step count divider ----------------
    logic        t_v;
    t_item       t_item_o;
    logic        t_neg;
    logic [30:0] t_rem;
    logic [8:0]  t_mod;

    lwi_tdiv u_tdiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s0_v),
        .i_item   (r_s0_item),
        .i_mag    (r_s0_mag),
        .i_neg    (r_s0_neg),
        .i_period (per_eff),
        .i_steps  (steps_eff),
        .o_valid  (t_v),
        .o_item   (t_item_o),
        .o_neg    (t_neg),
        .o_rem    (t_rem),
        .o_mod    (t_mod)
    );

    // ---------------- floor fixup and index wrap ----------------
    logic        rem_nz;
    logic [8:0]  idx9;
    logic [8:0]  nxt9;
    logic        r_s1_v;
    t_item       r_s1_item;
    logic [7:0]  r_s1_idx;
    logic [7:0]  r_s1_nxt;
    logic [30:0] r_s1_r;

    assign rem_nz = (t_rem != '0);

    always_comb begin
        if (!t_neg) begin
            idx9 = t_mod;
        end else if (rem_nz) begin
            idx9 = steps_eff - 9'd1 - t_mod;
        end else if (t_mod == '0) begin
            idx9 = '0;
        end else begin
            idx9 = steps_eff - t_mod;
        end
        nxt9 = idx9 + 9'd1;
        if (nxt9 == steps_eff) begin
            nxt9 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= t_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_item <= t_item_o;
        r_s1_idx  <= idx9[7:0];
        r_s1_nxt  <= nxt9[7:0];
        r_s1_r    <= (t_neg && rem_nz) ? (per_eff - t_rem) : t_rem;
    end

    // ---------------- waypoint store ----------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [63:0]       ram_wdata;
    logic [63:0]       rd_a;
    logic [63:0]       rd_b;

    assign ram_we    = r_s1_v && r_s1_item.is_wr;
    assign ram_waddr = {r_s1_item.tgt, r_s1_item.step};
    assign ram_wdata = {r_s1_item.x, r_s1_item.y};

    // two copies so the current and next entry come out in the same cycle
    lwi_ram #(.WIDTH(64), .DEPTH(STORE_DEPTH)) u_ram_cur (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr ({r_s1_item.tgt, r_s1_idx}),
        .o_rdata (rd_a)
    );

    lwi_ram #(.WIDTH(64), .DEPTH(STORE_DEPTH)) u_ram_nxt (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr ({r_s1_item.tgt, r_s1_nxt}),
        .o_rdata (rd_b)
    );

    logic        r_s2_v;
    t_tag        r_s2_tag;
    logic [30:0] r_s2_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_tag.is_wr <= r_s1_item.is_wr;
        r_s2_tag.err   <= r_s1_item.err;
        r_s2_r         <= r_s1_r;
    end

    // ---------------- difference ----------------
    logic        r_s3_v;
    t_tag        r_s3_tag;
    logic [30:0] r_s3_r;
    logic [31:0] r_s3_ax;
    logic [31:0] r_s3_ay;
    logic [32:0] r_s3_dx;
    logic [32:0] r_s3_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_tag <= r_s2_tag;
        r_s3_r   <= r_s2_r;
        r_s3_ax  <= rd_a[63:32];
        r_s3_ay  <= rd_a[31:0];
        r_s3_dx  <= {rd_b[63], rd_b[63:32]} - {rd_a[63], rd_a[63:32]};
        r_s3_dy  <= {rd_b[31], rd_b[31:0]} - {rd_a[31], rd_a[31:0]};
    end

    // ---------------- magnitude ----------------
    logic [32:0] abs_x;
    logic [32:0] abs_y;
    logic        r_s4_v;
    t_tag        r_s4_tag;
    logic [30:0] r_s4_r;
    logic [31:0] r_s4_ax;
    logic [31:0] r_s4_ay;
    logic [31:0] r_s4_mx;
    logic [31:0] r_s4_my;
    logic        r_s4_nx;
    logic        r_s4_ny;

    assign abs_x = r_s3_dx[32] ? (~r_s3_dx + 33'd1) : r_s3_dx;
    assign abs_y = r_s3_dy[32] ? (~r_s3_dy + 33'd1) : r_s3_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_tag <= r_s3_tag;
        r_s4_r   <= r_s3_r;
        r_s4_ax  <= r_s3_ax;
        r_s4_ay  <= r_s3_ay;
        r_s4_mx  <= abs_x[31:0];
        r_s4_my  <= abs_y[31:0];
        r_s4_nx  <= r_s3_dx[32];
        r_s4_ny  <= r_s3_dy[32];
    end

    // ---------------- product ----------------
    logic        r_s5_v;
    t_tag        r_s5_tag;
    logic [31:0] r_s5_ax;
    logic [31:0] r_s5_ay;
    logic [62:0] r_s5_px;
    logic [62:0] r_s5_py;
    logic        r_s5_nx;
    logic        r_s5_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else begin
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_tag <= r_s4_tag;
        r_s5_ax  <= r_s4_ax;
        r_s5_ay  <= r_s4_ay;
        r_s5_px  <= 63'(r_s4_mx) * 63'(r_s4_r);
        r_s5_py  <= 63'(r_s4_my) * 63'(r_s4_r);
        r_s5_nx  <= r_s4_nx;
        r_s5_ny  <= r_s4_ny;
    end

    // ---------------- fraction divider ----------------
    logic        l_v;
    t_tag        l_tag;
    logic [31:0] l_qx;
    logic [31:0] l_qy;
    logic        l_nx;
    logic        l_ny;
    logic [31:0] l_ax;
    logic [31:0] l_ay;

    lwi_ldiv u_ldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s5_v),
        .i_tag    (r_s5_tag),
        .i_period (per_eff),
        .i_num_x  (r_s5_px),
        .i_num_y  (r_s5_py),
        .i_neg_x  (r_s5_nx),
        .i_neg_y  (r_s5_ny),
        .i_a_x    (r_s5_ax),
        .i_a_y    (r_s5_ay),
        .o_valid  (l_v),
        .o_tag    (l_tag),
        .o_q_x    (l_qx),
        .o_q_y    (l_qy),
        .o_neg_x  (l_nx),
        .o_neg_y  (l_ny),
        .o_a_x    (l_ax),
        .o_a_y    (l_ay)
    );

    // ---------------- result ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            // writes end here without a transfer
            o_valid <= l_v && !l_tag.is_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        o_range_error <= l_tag.err;
        if (l_tag.err) begin
            o_pos_x <= '0;
            o_pos_y <= '0;
        end else begin
            o_pos_x <= l_nx ? (l_ax - l_qx) : (l_ax + l_qx);
            o_pos_y <= l_ny ? (l_ay - l_qy) : (l_ay + l_qy);
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the looped waypoint interpolator. Fills the waypoint
// table, queries positions across several register settings, and compares
// every result strobe with an in-bench prediction in transfer order.
// ----------------------------------------------------------------------------
module tb
    import lwi_pkg::*;
();

    localparam int LATENCY  = 71;
    localparam int WD_LIMIT = 3000;

    typedef struct {
        logic        req;
        logic [3:0]  tgt;
        logic [7:0]  step;
        logic [31:0] wx;
        logic [31:0] wy;
        logic [31:0] qtime;
    } t_req;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        err;
    } t_pos;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_PERIOD;
    logic [30:0] i_cfg_wdata = '0;
    logic        i_req_type = REQ_WRITE;
    logic [3:0]  i_target_sel = '0;
    logic [7:0]  i_step_sel = '0;
    logic [31:0] i_write_x = '0;
    logic [31:0] i_write_y = '0;
    logic [31:0] i_query_time = '0;
    logic        o_valid;
    logic [31:0] o_pos_x;
    logic [31:0] o_pos_y;
    logic        o_range_error;

    looped_waypoint_interpolator dut (.*);

    initial forever #5 i_clk = ~i_clk;

    // register shadows, only changed while the block is idle
    logic [30:0] period_reg  = 31'd65536;
    logic [8:0]  steps_reg   = 9'd256;
    logic [4:0]  targets_reg = 5'd16;

    logic [31:0] way_x [STORE_DEPTH];
    logic [31:0] way_y [STORE_DEPTH];
    bit          gen_written [STORE_DEPTH];

    t_req pend_q[$];
    t_pos pos_q[$];
    int   errors = 0;
    int   idle_cycles = 0;
    int   burst_left = 0;
    int   gap_left = 0;

    function automatic longint eff_period();
        return (period_reg == 0) ? 64'sd1 : longint'(period_reg);
    endfunction

    function automatic longint eff_steps();
        if (steps_reg == 0) return 1;
        if (steps_reg > MAX_STEPS) return MAX_STEPS;
        return longint'(steps_reg);
    endfunction

    function automatic int eff_targets();
        return (targets_reg > MAX_TARGETS) ? MAX_TARGETS : int'(targets_reg);
    endfunction

    // floor step count wrapped into the loop; also yields remainder
    function automatic void wrap_step(input logic [31:0] qt, output int cur,
                                      output int nxt, output longint rem);
        longint t, p, q, s, k;
        t = longint'(signed'(qt));
        p = eff_period();
        s = eff_steps();
        q = t / p;
        if (t - q * p < 0) q = q - 1;
        rem = t - q * p;
        k = q % s;
        if (k < 0) k = k + s;
        cur = int'(k);
        nxt = (k + 1 >= s) ? 0 : int'(k + 1);
    endfunction

    function automatic logic [31:0] lerp(input logic [31:0] a, input logic [31:0] b,
                                         input longint rem);
        longint sa, sb;
        sa = longint'(signed'(a));
        sb = longint'(signed'(b));
        return 32'(sa + ((sb - sa) * rem) / eff_period());
    endfunction

    function automatic t_pos predict_position(input t_req r);
        t_pos   res;
        int     cur, nxt, base;
        longint rem;
        res = '{x: '0, y: '0, err: 1'b1};
        if (int'(r.tgt) < eff_targets()) begin
            wrap_step(r.qtime, cur, nxt, rem);
            base = int'(r.tgt) * MAX_STEPS;
            res.x = lerp(way_x[base + cur], way_x[base + nxt], rem);
            res.y = lerp(way_y[base + cur], way_y[base + nxt], rem);
            res.err = 1'b0;
        end
        return res;
    endfunction

    task automatic push_write(input int tgt, input int step, input logic [31:0] x,
                              input logic [31:0] y);
        pend_q.push_back('{REQ_WRITE, 4'(tgt), 8'(step), x, y, $urandom});
        gen_written[tgt * MAX_STEPS + step] = 1'b1;
    endtask

    // fill any unwritten entry the query will read, then queue the query
    task automatic push_query(input int tgt, input logic [31:0] qt);
        int     cur, nxt;
        longint rem;
        if (tgt < eff_targets()) begin
            wrap_step(qt, cur, nxt, rem);
            if (!gen_written[tgt * MAX_STEPS + cur])
                push_write(tgt, cur, $urandom, $urandom);
            if (!gen_written[tgt * MAX_STEPS + nxt])
                push_write(tgt, nxt, $urandom, $urandom);
        end
        pend_q.push_back('{REQ_QUERY, 4'(tgt), 8'($urandom), $urandom, $urandom, qt});
    endtask

    function automatic logic [31:0] pick_time();
        longint k;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 4000)) - 32'd2000;
            default: begin
                k = longint'($urandom_range(0, 40)) - 20;
                return 32'(k * eff_period() + ($urandom_range(0, 1) ? eff_period() - 1 : 0));
            end
        endcase
    endfunction

    task automatic wait_idle();
        while (pend_q.size() != 0 || start || pos_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_PERIOD:  period_reg  = val;
            CFG_STEPS:   steps_reg   = val[8:0];
            default:     targets_reg = val[4:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // driver: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        t_req r;
        t_pos p;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                idle_cycles = 0;
                r = '{i_req_type, i_target_sel, i_step_sel, i_write_x, i_write_y,
                      i_query_time};
                if (r.req == REQ_WRITE) begin
                    way_x[int'(r.tgt) * MAX_STEPS + int'(r.step)] = r.wx;
                    way_y[int'(r.tgt) * MAX_STEPS + int'(r.step)] = r.wy;
                end else begin
                    p = predict_position(r);
                    pos_q.push_back(p);
                end
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    r = pend_q.pop_front();
                    i_req_type   <= r.req;
                    i_target_sel <= r.tgt;
                    i_step_sel   <= r.step;
                    i_write_x    <= r.wx;
                    i_write_y    <= r.wy;
                    i_query_time <= r.qtime;
                    start <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: one result per strobe, checked against the oldest prediction
    always @(posedge i_clk) begin
        t_pos e;
        if (i_rst_n && o_valid) begin
            idle_cycles = 0;
            if (pos_q.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h err=%b", $time, o_pos_x,
                         o_pos_y, o_range_error);
                errors++;
            end else begin
                e = pos_q.pop_front();
                if (o_pos_x !== e.x) begin
                    $display("%0t: pos_x expected %h actual %h", $time, e.x, o_pos_x);
                    errors++;
                end
                if (o_pos_y !== e.y) begin
                    $display("%0t: pos_y expected %h actual %h", $time, e.y, o_pos_y);
                    errors++;
                end
                if (o_range_error !== e.err) begin
                    $display("%0t: range_error expected %b actual %b", $time, e.err,
                             o_range_error);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer in either direction
    always @(posedge i_clk) begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("FAIL looped_waypoint_interpolator");
            $finish;
        end
    end

    initial begin
        logic [30:0] periods [6];
        logic [8:0]  steps [6];
        logic [4:0]  targets [6];
        int          n;
        periods = '{31'd1, 31'd0, 31'h7fffffff, 31'd65536, 31'd3, 31'h7fffffff};
        steps   = '{9'd1, 9'd0, 9'd256, 9'd5, 9'd511, 9'd2};
        targets = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd7, 5'd3};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes at reset settings
        push_write(0, 0, 32'h7fffffff, 32'h80000000);
        push_write(0, 1, 32'h80000000, 32'h7fffffff);
        push_write(0, 255, 32'h0, 32'hffffffff);
        push_write(15, 255, 32'hffffffff, 32'h0);
        push_query(0, 32'h0);
        push_query(0, 32'h00008000);
        push_query(0, 32'hffffffff);
        push_query(0, 32'h7fffffff);
        push_query(0, 32'h80000000);
        push_query(15, 32'h00ff0000);
        push_query(15, 32'hff000000);
        push_query(15, 32'h00ffffff);
        wait_idle();
        write_reg(CFG_TARGETS, 31'd2);
        push_query(1, 32'h0);
        push_query(2, 32'h12345678);
        push_query(15, 32'hffffffff);

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            write_reg(CFG_PERIOD, periods[ph]);
            write_reg(CFG_STEPS, steps[ph]);
            write_reg(CFG_TARGETS, targets[ph]);
            n = 0;
            while (n < 215) begin
                if ($urandom_range(0, 9) < 3)
                    push_write($urandom_range(0, 15), $urandom_range(0, 255),
                               $urandom, $urandom);
                else
                    push_query($urandom_range(0, 15), pick_time());
                n++;
            end
        end

        wait_idle();
        if (errors == 0)
            $display("PASS looped_waypoint_interpolator");
        else
            $display("FAIL looped_waypoint_interpolator");
        $finish;
    end
endmodule
